FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every rising edge, skipped while reset is asserted
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// check on every rising edge, reset included
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

FILE: rtl/core/fbw_pkg.sv
// ----------------------------------------------------------------------------
// fbw_pkg
// Types, codes and sizes shared by the fit selection block.
// ----------------------------------------------------------------------------
`default_nettype none

package fbw_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int SIZE_WIDTH  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_APPEND  = 2'd1;
    localparam logic [1:0] CMD_REQUEST = 2'd2;

    localparam logic [1:0] STS_ALLOCATED = 2'd0;
    localparam logic [1:0] STS_ZERO_REQ  = 2'd1;
    localparam logic [1:0] STS_NO_FIT    = 2'd2;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [SIZE_WIDTH-1:0] value;
    } fbw_in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [IDX_W-1:0]      first_index;
        logic [SIZE_WIDTH-1:0] first_size;
        logic [IDX_W-1:0]      best_index;
        logic [SIZE_WIDTH-1:0] best_size;
        logic [IDX_W-1:0]      worst_index;
        logic [SIZE_WIDTH-1:0] worst_size;
    } fbw_out_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic load_out;
    } fbw_ctl_t;

    typedef struct packed {
        logic is_request;
        logic scan_done;
        logic out_free;
    } fbw_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/fbw_ctrl.sv
// ----------------------------------------------------------------------------
// fbw_ctrl
// Sequencer: takes a word, runs the table scan for a request, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fbw_ctrl
    import fbw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire fbw_sts_t sts,
    output fbw_ctl_t      ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.accept = cmd_valid;
                if (cmd_valid && sts.is_request)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                ctl.load_out = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_RST(a_accept_idle, clk, rst_n, ctl.accept |-> (state_reg == S_IDLE))
    `ASSERT_RST(a_finish_exit, clk, rst_n, ctl.load_out |=> (state_reg == S_IDLE))
    `ASSERT_RST(a_scan_path, clk, rst_n,
        (state_reg == S_FINISH) |-> ($past(state_reg) == S_SCAN || $past(state_reg) == S_FINISH))

endmodule

`default_nettype wire

FILE: rtl/core/fbw_dpath.sv
// ----------------------------------------------------------------------------
// fbw_dpath
// Size table, scan pointer, fit trackers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fbw_dpath
    import fbw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire fbw_in_t  cmd_word,
    input  wire fbw_ctl_t ctl,
    output fbw_sts_t      sts,
    output logic          res_valid,
    input  wire logic     res_stall,
    output fbw_out_t      res_word
);

    logic [SIZE_WIDTH-1:0] mem [TABLE_DEPTH];

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      addr_reg;
    logic                  pend_reg;
    logic                  found_reg;
    logic                  out_valid_reg;
    logic [SIZE_WIDTH-1:0] req_reg;
    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [IDX_W-1:0]      first_idx_reg;
    logic [SIZE_WIDTH-1:0] first_size_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SIZE_WIDTH-1:0] best_size_reg;
    logic [IDX_W-1:0]      worst_idx_reg;
    logic [SIZE_WIDTH-1:0] worst_size_reg;
    fbw_out_t              out_reg;
    fbw_out_t              out_next;

    logic                  issue_done;
    logic                  append_ok;
    logic                  fits;

    assign issue_done     = (addr_reg == count_reg);
    assign append_ok      = (count_reg < CNT_W'(TABLE_DEPTH));
    assign fits           = pend_reg && (rd_data_reg >= req_reg);

    assign sts.is_request = (cmd_word.cmd == CMD_REQUEST);
    assign sts.scan_done  = issue_done && !pend_reg;
    assign sts.out_free   = !out_valid_reg || !res_stall;

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

    // table write on append, one registered read per scan step
    always_ff @(posedge clk)
    begin
        if (ctl.accept && (cmd_word.cmd == CMD_APPEND) && append_ok)
        begin
            mem[count_reg[IDX_W-1:0]] <= cmd_word.value;
        end
        if (ctl.step && !issue_done)
        begin
            rd_data_reg <= mem[addr_reg[IDX_W-1:0]];
            rd_idx_reg  <= addr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.accept)
            begin
                unique case (cmd_word.cmd)
                    CMD_CLEAR:
                    begin
                        count_reg <= '0;
                        addr_reg  <= '0;
                    end
                    CMD_APPEND:
                    begin
                        if (append_ok)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    CMD_REQUEST:
                    begin
                        found_reg <= 1'b0;
                        pend_reg  <= 1'b0;
                        addr_reg  <= (cmd_word.value == '0) ? count_reg : '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.step)
            begin
                pend_reg <= !issue_done;
                if (!issue_done)
                begin
                    addr_reg <= addr_reg + CNT_W'(1);
                end
                if (fits)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_next = '0;
        priority if (req_reg == '0)
        begin
            out_next.status = STS_ZERO_REQ;
        end
        else if (!found_reg)
        begin
            out_next.status = STS_NO_FIT;
        end
        else
        begin
            out_next.status      = STS_ALLOCATED;
            out_next.first_index = first_idx_reg;
            out_next.first_size  = first_size_reg;
            out_next.best_index  = best_idx_reg;
            out_next.best_size   = best_size_reg;
            out_next.worst_index = worst_idx_reg;
            out_next.worst_size  = worst_size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept && sts.is_request)
        begin
            req_reg <= cmd_word.value;
        end
        if (ctl.step && fits)
        begin
            if (!found_reg)
            begin
                first_idx_reg  <= rd_idx_reg;
                first_size_reg <= rd_data_reg;
                best_idx_reg   <= rd_idx_reg;
                best_size_reg  <= rd_data_reg;
                worst_idx_reg  <= rd_idx_reg;
                worst_size_reg <= rd_data_reg;
            end
            else
            begin
                if (rd_data_reg < best_size_reg)
                begin
                    best_idx_reg  <= rd_idx_reg;
                    best_size_reg <= rd_data_reg;
                end
                if (rd_data_reg > worst_size_reg)
                begin
                    worst_idx_reg  <= rd_idx_reg;
                    worst_size_reg <= rd_data_reg;
                end
            end
        end
        if (ctl.load_out)
        begin
            out_reg <= out_next;
        end
    end

    `ASSERT_RST(a_count_range, clk, rst_n, count_reg <= CNT_W'(TABLE_DEPTH))
    `ASSERT_RST(a_addr_range, clk, rst_n, addr_reg <= count_reg)
    `ASSERT_RST(a_fit_order, clk, rst_n,
        (found_reg && !ctl.accept) |-> (best_size_reg <= worst_size_reg &&
                                        best_size_reg >= req_reg &&
                                        first_size_reg >= best_size_reg))

endmodule

`default_nettype wire

FILE: rtl/core/first_best_worst_fit_select.sv
// ----------------------------------------------------------------------------
// first_best_worst_fit_select
// First, best and worst fit selection over a table of free block sizes.
//
// Input channel (cmd_valid / cmd_stall / cmd_word): a word carries a command
// and a value. Clear empties the table, append stores the value as the next
// block size (dropped when the table holds 16 entries), request searches the
// table for the value. Clear and append give no result. A request scans the
// table one entry per cycle through the table read port; an empty table or a
// zero request skips the scan.
// Output channel (res_valid / res_stall / res_word): one word per request
// with status and the three choices. The result sits in an output register,
// so the next word is taken while it waits; a request that finishes while
// that register is still stalled holds until it drains.
// Reset empties the table and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module first_best_worst_fit_select
    import fbw_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cmd_valid,
    output logic         cmd_stall,
    input  wire fbw_in_t cmd_word,
    output logic         res_valid,
    input  wire logic    res_stall,
    output fbw_out_t     res_word
);

    fbw_ctl_t ctl;
    fbw_sts_t sts;

    fbw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    fbw_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .ctl       (ctl),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

`default_nettype wire
